// File: rtl/npc_pkg.sv
`timescale 1ns / 1ps

package npc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_COUNTERS_DEF = 16;
    localparam int MAX_DEPTH_DEF    = 8;
    localparam int TIME_BITS_DEF    = 32;

    // Configuration register reset values
    localparam logic [4:0] CFG_COUNTERS_RESET = 5'd16;
    localparam logic [3:0] CFG_DEPTH_RESET    = 4'd8;

    typedef enum logic {
        REG_COUNTERS = 1'b0,
        REG_DEPTH    = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_STOP  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_REJECT = 2'd1,
        STATUS_EMPTY  = 2'd2
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the input beat
        logic decode;    // latch status code and nesting info
        logic do_start;  // push id, record start time, zero child time
        logic do_pop;    // pop the stack
        logic do_clear;  // empty stack and totals
        logic stack_rd;  // read top and parent ids
        logic sum_rd;    // read totals of the item's id
        logic entry_rd;  // read per-counter entries of the popped id
        logic ticks;     // measure elapsed ticks
        logic accum;     // credit parent, form exclusive delta
        logic sums;      // update totals
        logic out_load;  // load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        func_t func;
        logic  start_ok;
        logic  stop_ok;
    } sts_t;

endpackage

// File: rtl/nested_profiling_counters.sv
`timescale 1ns / 1ps

// Nested profiling counters.
// Input channel (in_valid/in_ready) carries one beat per operation: func,
// counter_id and timestamp. Output channel (out_valid/out_ready) returns one
// result beat per input beat, in order: status, which_counter, elapsed_time
// and the counter's inclusive and exclusive totals.
// Configuration goes through the APB port: counters_in_use at 0x0,
// stack_depth_in_use at 0x4. pready is tied high; writes land on the access
// phase. Write only while the block is idle.
// One item is in flight at a time. Start, read and clear go from decode
// straight to the result; a stop first runs the sequence of stack read,
// entry read, tick compare, parent credit and 64-bit total update, each a
// registered memory access or add. The next beat is taken in the cycle
// after the result is loaded.
// When the receiver stalls, the finished result waits in the output register
// while the next beat is already accepted and worked on; that item then holds
// in its final step until the register frees up.
// Reset empties the stack, marks every total as zero and restores the
// registers to 16 counters and depth 8. No clearing pass is needed.
module nested_profiling_counters #(
    parameter int MAX_COUNTERS = npc_pkg::MAX_COUNTERS_DEF,
    parameter int MAX_DEPTH    = npc_pkg::MAX_DEPTH_DEF,
    parameter int TIME_BITS    = npc_pkg::TIME_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input channel
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   func,
    input  logic [3:0]   counter_id,
    input  logic [31:0]  timestamp,
    // output channel
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   status,
    output logic [3:0]   which_counter,
    output logic [31:0]  elapsed_time,
    output logic [63:0]  inclusive_total,
    output logic [63:0]  exclusive_total
);

    logic [4:0]             cfg_counters_reg;
    logic [3:0]             cfg_depth_reg;
    logic                   cfg_write;
    npc_pkg::reg_index_t    cfg_index;
    npc_pkg::cmd_t          cmd;
    npc_pkg::sts_t          sts;

    assign pready    = 1'b1;
    assign cfg_index = npc_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register file: write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_counters_reg <= npc_pkg::CFG_COUNTERS_RESET;
            cfg_depth_reg    <= npc_pkg::CFG_DEPTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                npc_pkg::REG_COUNTERS: cfg_counters_reg <= pwdata[4:0];
                npc_pkg::REG_DEPTH:    cfg_depth_reg    <= pwdata[3:0];
                default:               cfg_depth_reg    <= cfg_depth_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            npc_pkg::REG_COUNTERS: prdata = 32'(cfg_counters_reg);
            npc_pkg::REG_DEPTH:    prdata = 32'(cfg_depth_reg);
            default:               prdata = 32'd0;
        endcase
    end

    // Sequencer: walks each item through its steps
    npc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Stack, per-counter stores, arithmetic and result register
    npc_datapath #(
        .MAX_COUNTERS (MAX_COUNTERS),
        .MAX_DEPTH    (MAX_DEPTH),
        .TIME_BITS    (TIME_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_counters    (cfg_counters_reg),
        .cfg_depth       (cfg_depth_reg),
        .func            (func),
        .counter_id      (counter_id),
        .timestamp       (timestamp),
        .cmd             (cmd),
        .sts             (sts),
        .status          (status),
        .which_counter   (which_counter),
        .elapsed_time    (elapsed_time),
        .inclusive_total (inclusive_total),
        .exclusive_total (exclusive_total)
    );

    // One item at a time: no beat is taken right after another
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input beat accepted while an item is in flight");

    // The result register is never overwritten while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result register loaded over a pending result");

    // Stop on an empty stack reports nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == npc_pkg::STATUS_EMPTY) |->
        (which_counter == 4'd0 && elapsed_time == 32'd0 &&
         inclusive_total == 64'd0 && exclusive_total == 64'd0))
        else $error("empty-stack stop carries payload");

    // A refused item measures no time
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != npc_pkg::STATUS_OK) |-> elapsed_time == 32'd0)
        else $error("elapsed time on a refused item");

endmodule

// File: rtl/npc_ctrl.sv
`timescale 1ns / 1ps

module npc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  npc_pkg::sts_t  sts,
    output npc_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ENTRY,
        S_TICKS,
        S_ACCUM,
        S_SUMS,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = S_FINISH;
                case (sts.func)
                    npc_pkg::FUNC_START: cmd.do_start = sts.start_ok;
                    npc_pkg::FUNC_STOP:
                    begin
                        cmd.do_pop   = sts.stop_ok;
                        cmd.stack_rd = sts.stop_ok;
                        if (sts.stop_ok)
                        begin
                            state_next = S_ENTRY;
                        end
                    end
                    npc_pkg::FUNC_READ:  cmd.sum_rd   = 1'b1;
                    npc_pkg::FUNC_CLEAR: cmd.do_clear = 1'b1;
                    default:             cmd.do_clear = 1'b0;
                endcase
            end
            S_ENTRY:
            begin
                cmd.entry_rd = 1'b1;
                state_next   = S_TICKS;
            end
            S_TICKS:
            begin
                cmd.ticks  = 1'b1;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = S_SUMS;
            end
            S_SUMS:
            begin
                cmd.sums   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the result register is free
                cmd.out_load = !out_valid_reg || out_ready;
                if (cmd.out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/npc_datapath.sv
`timescale 1ns / 1ps

module npc_datapath #(
    parameter int MAX_COUNTERS = npc_pkg::MAX_COUNTERS_DEF,
    parameter int MAX_DEPTH    = npc_pkg::MAX_DEPTH_DEF,
    parameter int TIME_BITS    = npc_pkg::TIME_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [4:0]     cfg_counters,
    input  logic [3:0]     cfg_depth,
    input  logic [1:0]     func,
    input  logic [3:0]     counter_id,
    input  logic [31:0]    timestamp,
    input  npc_pkg::cmd_t  cmd,
    output npc_pkg::sts_t  sts,
    output logic [1:0]     status,
    output logic [3:0]     which_counter,
    output logic [31:0]    elapsed_time,
    output logic [63:0]    inclusive_total,
    output logic [63:0]    exclusive_total
);

    localparam int IDX_W = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;
    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SP_W  = $clog2(MAX_DEPTH + 1);

    // Captured item
    npc_pkg::func_t        func_reg;
    logic [3:0]            id_reg;
    logic [TIME_BITS-1:0]  now_reg;

    // Control state
    logic [SP_W-1:0]          sp_reg;
    logic [SP_W-1:0]          sp_next;
    logic [MAX_COUNTERS-1:0]  valid_reg;
    npc_pkg::status_t         status_reg;
    logic                     has_parent_reg;

    // Stores
    logic [IDX_W-1:0]      stack_mem [MAX_DEPTH];
    logic [TIME_BITS-1:0]  time_mem  [MAX_COUNTERS];
    logic [31:0]           child_mem [MAX_COUNTERS];
    logic [63:0]           incl_mem  [MAX_COUNTERS];
    logic [63:0]           excl_mem  [MAX_COUNTERS];

    // Registered read data
    logic [IDX_W-1:0]      top_reg;
    logic [IDX_W-1:0]      parent_reg;
    logic [TIME_BITS-1:0]  start_rd_reg;
    logic [31:0]           child_top_reg;
    logic [31:0]           child_par_reg;
    logic [63:0]           incl_rd_reg;
    logic [63:0]           excl_rd_reg;
    logic                  valid_rd_reg;

    // Arithmetic stages
    logic [TIME_BITS-1:0]  ticks_reg;
    logic [TIME_BITS-1:0]  ticks_next;
    logic [31:0]           delta_reg;
    logic [31:0]           delta_next;
    logic [63:0]           incl_new_reg;
    logic [63:0]           excl_new_reg;
    logic [63:0]           incl_next;
    logic [63:0]           excl_next;

    // Result register
    logic [1:0]   status_out_reg;
    logic [3:0]   which_out_reg;
    logic [31:0]  elapsed_out_reg;
    logic [63:0]  incl_out_reg;
    logic [63:0]  excl_out_reg;
    logic [1:0]   status_out_next;
    logic [3:0]   which_out_next;
    logic [31:0]  elapsed_out_next;
    logic [63:0]  incl_out_next;
    logic [63:0]  excl_out_next;

    logic              id_ok;
    logic              start_ok;
    logic              stop_ok;
    logic [IDX_W-1:0]  id_idx;
    logic [AW-1:0]     top_addr;
    logic [AW-1:0]     par_addr;
    logic [IDX_W-1:0]  sum_addr;
    logic              same_id;
    logic              child_we;
    logic [IDX_W-1:0]  child_waddr;
    logic [31:0]       child_wdata;

    assign id_idx  = IDX_W'(id_reg);
    assign id_ok   = (9'(id_reg) < 9'(cfg_counters)) && (9'(id_reg) < 9'(MAX_COUNTERS));
    assign start_ok = id_ok && (7'(sp_reg) < 7'(cfg_depth)) && (7'(sp_reg) < 7'(MAX_DEPTH));
    assign stop_ok  = (sp_reg != '0);

    assign sts.func     = func_reg;
    assign sts.start_ok = start_ok;
    assign sts.stop_ok  = stop_ok;

    assign top_addr = AW'(sp_reg - SP_W'(1));
    assign par_addr = AW'(sp_reg - SP_W'(2));
    assign sum_addr = cmd.entry_rd ? top_reg : id_idx;

    // Nested restart of the same id: the parent credit lands on this entry too
    assign same_id = has_parent_reg && (parent_reg == top_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= npc_pkg::func_t'(func);
            id_reg   <= counter_id;
            now_reg  <= timestamp[TIME_BITS-1:0];
        end
    end

    always_comb
    begin
        sp_next = sp_reg;
        if (cmd.do_clear)
        begin
            sp_next = '0;
        end
        else if (cmd.do_start)
        begin
            sp_next = sp_reg + SP_W'(1);
        end
        else if (cmd.do_pop)
        begin
            sp_next = sp_reg - SP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg    <= '0;
            valid_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
            if (cmd.do_clear)
            begin
                valid_reg <= '0;
            end
            else if (cmd.sums)
            begin
                valid_reg[top_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            has_parent_reg <= (sp_reg > SP_W'(1));
            case (func_reg)
                npc_pkg::FUNC_START:
                    status_reg <= start_ok ? npc_pkg::STATUS_OK : npc_pkg::STATUS_REJECT;
                npc_pkg::FUNC_STOP:
                    status_reg <= stop_ok ? npc_pkg::STATUS_OK : npc_pkg::STATUS_EMPTY;
                npc_pkg::FUNC_READ:
                    status_reg <= id_ok ? npc_pkg::STATUS_OK : npc_pkg::STATUS_REJECT;
                default:
                    status_reg <= npc_pkg::STATUS_OK;
            endcase
        end
    end

    // Id stack: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (cmd.do_start)
        begin
            stack_mem[AW'(sp_reg)] <= id_idx;
        end
        if (cmd.stack_rd)
        begin
            top_reg    <= stack_mem[top_addr];
            parent_reg <= stack_mem[par_addr];
        end
    end

    // Start times
    always_ff @(posedge clk)
    begin
        if (cmd.do_start)
        begin
            time_mem[id_idx] <= now_reg;
        end
        if (cmd.entry_rd)
        begin
            start_rd_reg <= time_mem[top_reg];
        end
    end

    // Child times: one write port, two read ports
    assign child_we    = cmd.do_start || (cmd.accum && has_parent_reg);
    assign child_waddr = cmd.do_start ? id_idx : parent_reg;
    assign child_wdata = cmd.do_start ? 32'd0 : (child_par_reg + 32'(ticks_reg));

    always_ff @(posedge clk)
    begin
        if (child_we)
        begin
            child_mem[child_waddr] <= child_wdata;
        end
        if (cmd.entry_rd)
        begin
            child_top_reg <= child_mem[top_reg];
            child_par_reg <= child_mem[parent_reg];
        end
    end

    // Totals
    always_ff @(posedge clk)
    begin
        if (cmd.sums)
        begin
            incl_mem[top_reg] <= incl_next;
            excl_mem[top_reg] <= excl_next;
        end
        if (cmd.sum_rd || cmd.entry_rd)
        begin
            incl_rd_reg  <= incl_mem[sum_addr];
            excl_rd_reg  <= excl_mem[sum_addr];
            valid_rd_reg <= valid_reg[sum_addr];
        end
    end

    // Wrapped clock measures zero
    assign ticks_next = (now_reg >= start_rd_reg) ? (now_reg - start_rd_reg) : '0;
    assign delta_next = same_id ? (32'd0 - child_top_reg)
                                : (32'(ticks_reg) - child_top_reg);
    assign incl_next  = (valid_rd_reg ? incl_rd_reg : 64'd0) + 64'(ticks_reg);
    assign excl_next  = (valid_rd_reg ? excl_rd_reg : 64'd0) + 64'(delta_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.ticks)
        begin
            ticks_reg <= ticks_next;
        end
        if (cmd.accum)
        begin
            delta_reg <= delta_next;
        end
        if (cmd.sums)
        begin
            incl_new_reg <= incl_next;
            excl_new_reg <= excl_next;
        end
    end

    always_comb
    begin
        status_out_next  = status_reg;
        which_out_next   = 4'd0;
        elapsed_out_next = 32'd0;
        incl_out_next    = 64'd0;
        excl_out_next    = 64'd0;
        case (func_reg)
            npc_pkg::FUNC_START:
            begin
                which_out_next = id_reg;
            end
            npc_pkg::FUNC_STOP:
            begin
                if (status_reg == npc_pkg::STATUS_OK)
                begin
                    which_out_next   = 4'(top_reg);
                    elapsed_out_next = 32'(ticks_reg);
                    incl_out_next    = incl_new_reg;
                    excl_out_next    = excl_new_reg;
                end
            end
            npc_pkg::FUNC_READ:
            begin
                which_out_next = id_reg;
                if (status_reg == npc_pkg::STATUS_OK && valid_rd_reg)
                begin
                    incl_out_next = incl_rd_reg;
                    excl_out_next = excl_rd_reg;
                end
            end
            default:
            begin
                which_out_next = 4'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_out_reg  <= status_out_next;
            which_out_reg   <= which_out_next;
            elapsed_out_reg <= elapsed_out_next;
            incl_out_reg    <= incl_out_next;
            excl_out_reg    <= excl_out_next;
        end
    end

    assign status          = status_out_reg;
    assign which_counter   = which_out_reg;
    assign elapsed_time    = elapsed_out_reg;
    assign inclusive_total = incl_out_reg;
    assign exclusive_total = excl_out_reg;

endmodule

// File: verif/tb_nested_profiling_counters.sv
`timescale 1ns / 1ps

module tb_nested_profiling_counters;

    // Give the watchdog plenty of room: stops run a longer sequence, and both
    // sides stall at random.
    localparam int CYCLE_LIMIT   = 200000;
    // Let the block settle after the last result before touching registers.
    localparam int SETTLE_CYCLES = 12;
    localparam int NUM_PHASES    = 8;

    // Register settings per random phase. Extremes included. A phase that
    // lowers the limits usually starts with counters still on the stack.
    localparam int PHASE_IDS    [NUM_PHASES] = '{16, 5, 16, 1, 0, 11, 16, 16};
    localparam int PHASE_DEPTH  [NUM_PHASES] = '{8, 3, 8, 1, 0, 6, 2, 8};
    localparam int PHASE_ITEMS  [NUM_PHASES] = '{250, 150, 200, 80, 40, 130, 100, 150};
    localparam bit PHASE_STEADY [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 0, 0};

    typedef struct {
        npc_pkg::status_t status;
        logic [3:0]       which;
        logic [31:0]      elapsed;
        logic [63:0]      incl;
        logic [63:0]      excl;
    } prof_result_t;

    // Shadow of the counter stack and totals, plus the queue of results
    // still owed by the block.
    class profile_scoreboard;
        int unsigned  id_limit;
        int unsigned  depth_limit;
        int unsigned  stack_level;
        logic [3:0]   id_stack    [npc_pkg::MAX_DEPTH_DEF];
        logic [31:0]  start_stamp [npc_pkg::MAX_COUNTERS_DEF];
        logic [31:0]  child_ticks [npc_pkg::MAX_COUNTERS_DEF];
        logic [63:0]  incl_sum    [npc_pkg::MAX_COUNTERS_DEF];
        logic [63:0]  excl_sum    [npc_pkg::MAX_COUNTERS_DEF];
        prof_result_t pending_results [$];
        int unsigned  errors;

        function new();
            id_limit    = npc_pkg::CFG_COUNTERS_RESET;
            depth_limit = npc_pkg::CFG_DEPTH_RESET;
            errors      = 0;
            wipe();
        endfunction

        function void wipe();
            stack_level = 0;
            for (int i = 0; i < npc_pkg::MAX_DEPTH_DEF; i++)
                id_stack[i] = '0;
            for (int i = 0; i < npc_pkg::MAX_COUNTERS_DEF; i++)
            begin
                start_stamp[i] = '0;
                child_ticks[i] = '0;
                incl_sum[i]    = '0;
                excl_sum[i]    = '0;
            end
        endfunction

        function int unsigned usable_ids();
            return (id_limit > npc_pkg::MAX_COUNTERS_DEF) ? npc_pkg::MAX_COUNTERS_DEF
                                                          : id_limit;
        endfunction

        function int unsigned usable_depth();
            return (depth_limit > npc_pkg::MAX_DEPTH_DEF) ? npc_pkg::MAX_DEPTH_DEF
                                                          : depth_limit;
        endfunction

        function void flag_if_differs(string what, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch on %s: expected %0h, got %0h", what, want, got);
            end
        endfunction

        // Apply one accepted input beat and queue the result it must produce.
        function void predict_op(npc_pkg::func_t op, logic [3:0] id, logic [31:0] now);
            prof_result_t res;
            logic [3:0]   top;
            logic [3:0]   parent;
            logic [31:0]  ticks;
            logic [31:0]  own_ticks;
            res = '{npc_pkg::STATUS_OK, 4'd0, 32'd0, 64'd0, 64'd0};
            case (op)
                npc_pkg::FUNC_START:
                begin
                    res.which = id;
                    if (id >= usable_ids() || stack_level >= usable_depth())
                        res.status = npc_pkg::STATUS_REJECT;
                    else
                    begin
                        id_stack[stack_level] = id;
                        stack_level++;
                        child_ticks[id] = '0;
                        start_stamp[id] = now;
                    end
                end
                npc_pkg::FUNC_STOP:
                begin
                    if (stack_level == 0)
                        res.status = npc_pkg::STATUS_EMPTY;
                    else
                    begin
                        stack_level--;
                        top = id_stack[stack_level];
                        // A stop stamped before its start means the clock wrapped.
                        ticks = (now >= start_stamp[top]) ? now - start_stamp[top] : 32'd0;
                        // Credit the parent first; with recursion it is the same counter.
                        if (stack_level > 0)
                        begin
                            parent = id_stack[stack_level - 1];
                            child_ticks[parent] = child_ticks[parent] + ticks;
                        end
                        own_ticks = ticks - child_ticks[top];
                        incl_sum[top] = incl_sum[top] + 64'(ticks);
                        excl_sum[top] = excl_sum[top] + 64'(own_ticks);
                        res.which   = top;
                        res.elapsed = ticks;
                        res.incl    = incl_sum[top];
                        res.excl    = excl_sum[top];
                    end
                end
                npc_pkg::FUNC_READ:
                begin
                    res.which = id;
                    if (id >= usable_ids())
                        res.status = npc_pkg::STATUS_REJECT;
                    else
                    begin
                        res.incl = incl_sum[id];
                        res.excl = excl_sum[id];
                    end
                end
                default:
                    wipe();
            endcase
            pending_results.push_back(res);
        endfunction

        // Compare one accepted result beat against the oldest expectation.
        function void check_result(prof_result_t got);
            prof_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result beat with nothing expected: status %0d counter %0d",
                             got.status, got.which);
                return;
            end
            want = pending_results.pop_front();
            flag_if_differs("status", want.status, got.status);
            flag_if_differs("which_counter", want.which, got.which);
            flag_if_differs("elapsed_time", want.elapsed, got.elapsed);
            flag_if_differs("inclusive_total", want.incl, got.incl);
            flag_if_differs("exclusive_total", want.excl, got.excl);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [3:0]  counter_id;
    logic [31:0] timestamp;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [3:0]  which_counter;
    logic [31:0] elapsed_time;
    logic [63:0] inclusive_total;
    logic [63:0] exclusive_total;

    profile_scoreboard tracker;
    int unsigned       cycle_count;
    // Suppress idling on both sides while set.
    bit                steady;
    // Free-running clock value the random sequences advance.
    logic [31:0]       clock_now;

    nested_profiling_counters DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .counter_id      (counter_id),
        .timestamp       (timestamp),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .which_counter   (which_counter),
        .elapsed_time    (elapsed_time),
        .inclusive_total (inclusive_total),
        .exclusive_total (exclusive_total)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: sample at the edge, check every accepted beat, then pick
    // the next ready level. Stall about one cycle in five unless steady.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.check_result(prof_result_t'{npc_pkg::status_t'(status),
                                                     which_counter, elapsed_time,
                                                     inclusive_total, exclusive_total});
            out_ready <= steady || ($urandom_range(99, 0) >= 20);
        end
    end

    // Drive one operation beat. Idle a few cycles first at random; hold valid
    // and payload until the beat is taken. Valid stays high on return so the
    // next beat can follow back to back.
    task automatic send_beat(npc_pkg::func_t op, logic [3:0] id, logic [31:0] stamp);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99, 0) < 20)
            gap = $urandom_range(4, 1);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        counter_id <= id;
        timestamp  <= stamp;
        do @(posedge clk); while (!in_ready);
        tracker.predict_op(op, id, stamp);
    endtask

    // Drop valid and hold off until every owed result is back, then let the
    // block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a register over APB (setup, access), then read it back the same way.
    // End by returning the bus to idle so a following transfer starts on a fresh edge.
    task automatic program_reg(npc_pkg::reg_index_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == npc_pkg::REG_COUNTERS)
            tracker.id_limit = value;
        else
            tracker.depth_limit = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.flag_if_differs(idx == npc_pkg::REG_COUNTERS ? "counters_in_use readback"
                                                             : "stack_depth_in_use readback",
                                value, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed nesting: push on an empty stack, pop on a full one, else
    // either at random, with reads mixed in. A little noise and an occasional clear on top.
    task automatic random_item();
        int         pick;
        logic [3:0] id;
        pick = $urandom_range(99, 0);
        if ($urandom_range(99, 0) < 3)
            clock_now = $urandom();
        else
            clock_now = clock_now + $urandom_range(40, 0);
        if (tracker.usable_ids() > 0 && $urandom_range(9, 0) != 0)
            id = 4'($urandom_range(tracker.usable_ids() - 1, 0));
        else
            id = 4'($urandom_range(15, 0));
        if (pick < 3)
            send_beat(npc_pkg::FUNC_CLEAR, id, clock_now);
        else if (pick < 10)
            send_beat(npc_pkg::func_t'($urandom_range(3, 0)),
                      4'($urandom_range(15, 0)), $urandom());
        else if (pick < 25)
            send_beat(npc_pkg::FUNC_READ, id, clock_now);
        else if (tracker.stack_level == 0 ||
                 (tracker.stack_level < tracker.usable_depth() && $urandom_range(1, 0) == 1))
            send_beat(npc_pkg::FUNC_START, id, clock_now);
        else
            send_beat(npc_pkg::FUNC_STOP, id, clock_now);
    endtask

    initial
    begin
        tracker     = new();
        cycle_count = 0;
        steady      = 1'b0;
        clock_now   = '0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        func        = npc_pkg::FUNC_START;
        counter_id  = '0;
        timestamp   = '0;
        out_ready   = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset settings (16 counters, depth 8).
        // Pop an empty stack, read an untouched counter.
        send_beat(npc_pkg::FUNC_STOP, 4'd7, 32'd0);
        send_beat(npc_pkg::FUNC_READ, 4'd0, 32'd0);
        // Measure the full clock range on the top id.
        send_beat(npc_pkg::FUNC_START, 4'd15, 32'h0000_0000);
        send_beat(npc_pkg::FUNC_STOP, 4'd0, 32'hFFFF_FFFF);
        send_beat(npc_pkg::FUNC_READ, 4'd15, 32'hFFFF_FFFF);
        // Nest with recursion on one id, then a stop stamped before its start.
        send_beat(npc_pkg::FUNC_START, 4'd0, 32'd100);
        send_beat(npc_pkg::FUNC_START, 4'd1, 32'd200);
        send_beat(npc_pkg::FUNC_START, 4'd1, 32'd250);
        send_beat(npc_pkg::FUNC_STOP, 4'd0, 32'd260);
        send_beat(npc_pkg::FUNC_STOP, 4'd0, 32'd150);
        send_beat(npc_pkg::FUNC_STOP, 4'd0, 32'd1000);
        // Child time exceeds a wrapped parent: the exclusive delta wraps.
        send_beat(npc_pkg::FUNC_START, 4'd3, 32'd10);
        send_beat(npc_pkg::FUNC_START, 4'd4, 32'd20);
        send_beat(npc_pkg::FUNC_STOP, 4'd0, 32'd30);
        send_beat(npc_pkg::FUNC_STOP, 4'd0, 32'd5);
        // Fill the stack, get refused on the next push, then wipe everything.
        for (int i = 0; i < npc_pkg::MAX_DEPTH_DEF; i++)
            send_beat(npc_pkg::FUNC_START, 4'(i + 2), 32'(2000 + 10 * i));
        send_beat(npc_pkg::FUNC_START, 4'd10, 32'd3000);
        send_beat(npc_pkg::FUNC_CLEAR, 4'd9, 32'hA5A5_5A5A);
        send_beat(npc_pkg::FUNC_STOP, 4'd2, 32'd4000);

        // Random phases. Each one drains the block, reprograms both
        // registers and runs its share of items.
        clock_now = 32'd5000;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            program_reg(npc_pkg::REG_COUNTERS, PHASE_IDS[p]);
            program_reg(npc_pkg::REG_DEPTH, PHASE_DEPTH[p]);
            steady = PHASE_STEADY[p];
            for (int n = 0; n < PHASE_ITEMS[p]; n++)
                random_item();
        end

        // Wait out the last results, then give any stray beat time to show.
        drain();
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
